// ===== hw/rtl/pd_quad_motor_mixer_top_macros.svh =====
// Assertion macros shared by the motor mixer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PD_QUAD_MOTOR_MIXER_TOP_MACROS_SVH
`define PD_QUAD_MOTOR_MIXER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDQMM_ASSERT_NOW(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDQMM_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/pdqmm_pkg.sv =====
// Package for the quadcopter PD motor mixer: widths, beat layouts,
// register indexes and the arithmetic helpers. Depends on nothing.
package pdqmm_pkg;

    // Fractional bits of the Q-format gains.
    localparam int GAIN_FRAC_BITS = 8;

    localparam int DATA_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int MOTOR_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Gain is zero-extended to a signed operand, times a 16-bit signed rate.
    localparam int PROD_W   = GAIN_W + 1 + DATA_W;
    localparam int SCALED_W = PROD_W - GAIN_FRAC_BITS;
    localparam int CORR_W   = SCALED_W + 1;
    localparam int MIX_W    = CORR_W + 2;

    localparam int IN_W  = 7 * DATA_W;
    localparam int OUT_W = 4 * MOTOR_W;

    localparam logic signed [MIX_W-1:0] MIX_MAX = MIX_W'((2 ** (MOTOR_W - 1)) - 1);
    localparam logic signed [MIX_W-1:0] MIX_MIN = MIX_W'(-(2 ** (MOTOR_W - 1)));

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_ROLL    = 3'd0,
        CFG_KP_PITCH   = 3'd1,
        CFG_KP_YAW     = 3'd2,
        CFG_KD_ROLL    = 3'd3,
        CFG_KD_PITCH   = 3'd4,
        CFG_KD_YAW     = 3'd5,
        CFG_TILT_LIMIT = 3'd6,
        CFG_YAW_LIMIT  = 3'd7
    } cfg_reg_t;

    // Input beat, last member in the lowest bits.
    typedef struct packed {
        logic        [DATA_W-1:0] thrust;
        logic signed [DATA_W-1:0] gyro_z;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] yaw_error;
        logic signed [DATA_W-1:0] pitch_error;
        logic signed [DATA_W-1:0] roll_error;
    } in_item_t;

    // Result beat, last member in the lowest bits.
    typedef struct packed {
        logic signed [MOTOR_W-1:0] motor3;
        logic signed [MOTOR_W-1:0] motor2;
        logic signed [MOTOR_W-1:0] motor1;
        logic signed [MOTOR_W-1:0] motor0;
    } out_item_t;

    // Scaled gain terms passed from the multipliers to the mix logic.
    typedef struct packed {
        logic signed [SCALED_W-1:0] roll_p;
        logic signed [SCALED_W-1:0] roll_d;
        logic signed [SCALED_W-1:0] pitch_p;
        logic signed [SCALED_W-1:0] pitch_d;
        logic signed [SCALED_W-1:0] yaw_p;
        logic signed [SCALED_W-1:0] yaw_d;
        logic        [DATA_W-1:0]   thrust;
    } terms_t;

    // Symmetric clamp of a signed rate to +-lim.
    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [DATA_W-1:0] x,
        input logic [LIMIT_W-1:0] lim
    );
        logic signed [DATA_W:0] x_ext;
        logic signed [DATA_W:0] hi;
        logic signed [DATA_W:0] lo;
        logic signed [DATA_W:0] res;
        x_ext = {x[DATA_W-1], x};
        hi    = $signed({{(DATA_W + 1 - LIMIT_W){1'b0}}, lim});
        lo    = -hi;
        if (x_ext > hi) begin
            res = hi;
        end else if (x_ext < lo) begin
            res = lo;
        end else begin
            res = x_ext;
        end
        return res[DATA_W-1:0];
    endfunction

    // Gain times value, then floor shift by the fractional bits.
    function automatic logic signed [SCALED_W-1:0] scale(
        input logic [GAIN_W-1:0] gain,
        input logic signed [DATA_W-1:0] x
    );
        logic signed [PROD_W-1:0] prod;
        prod = $signed({1'b0, gain}) * x;
        return prod[PROD_W-1:GAIN_FRAC_BITS];
    endfunction

    // Saturate a mixed value to the motor range.
    function automatic logic signed [MOTOR_W-1:0] sat_motor(
        input logic signed [MIX_W-1:0] v
    );
        logic signed [MIX_W-1:0] res;
        if (v > MIX_MAX) begin
            res = MIX_MAX;
        end else if (v < MIX_MIN) begin
            res = MIX_MIN;
        end else begin
            res = v;
        end
        return res[MOTOR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pd_quad_motor_mixer_top.sv =====
// Top level of the quadcopter PD attitude motor mixer.
// Depends on pdqmm_pkg and pd_quad_motor_mixer_top_macros.svh.

// The mixer takes one beat of attitude errors, gyro rates and thrust per
// cycle and returns one beat of four saturated 24-bit motor commands. Each
// beat passes two registers: the input register and the output register.
// Between them one pass of logic clamps the gyro rates, forms the six gain
// products, sums the corrections, mixes them into the motors and saturates.
// A beat accepted into the input register is loaded into the output
// register once that stage can take it, which raises m_tvalid, and a new
// beat can enter every cycle while m_tready stays high. When m_tready is
// low both stages hold, so up to two beats are in flight before s_tready
// drops; s_tready follows m_tready combinationally once both are full.
// Gains and rate limits are written through the cfg port, which is always
// ready; writes are expected only while no beat is in flight.

`include "pd_quad_motor_mixer_top_macros.svh"

module pd_quad_motor_mixer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // roll_error, pitch_error, yaw_error, gyro_x, gyro_y, gyro_z, thrust
    input  logic [pdqmm_pkg::IN_W-1:0]          s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // motor0, motor1, motor2, motor3
    output logic [pdqmm_pkg::OUT_W-1:0]         m_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdqmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdqmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pdqmm_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]  kp_roll_reg, kp_pitch_reg, kp_yaw_reg;
    logic [GAIN_W-1:0]  kd_roll_reg, kd_pitch_reg, kd_yaw_reg;
    logic [LIMIT_W-1:0] tilt_limit_reg, yaw_limit_reg;

    // Pipeline registers.
    in_item_t  in_reg;
    logic      in_valid_reg;
    terms_t    terms;
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;

    logic out_ready;
    logic in_ready;

    // Stall chain: a stage takes a new beat when empty or when it drains.
    assign out_ready   = !out_valid_reg || m_tready;
    assign in_ready    = !in_valid_reg || out_ready;

    assign s_tready  = in_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    // Register writes; unused value bits above a register's width are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_roll_reg    <= GAIN_W'(256);
            kp_pitch_reg   <= GAIN_W'(256);
            kp_yaw_reg     <= GAIN_W'(256);
            kd_roll_reg    <= '0;
            kd_pitch_reg   <= '0;
            kd_yaw_reg     <= '0;
            tilt_limit_reg <= '1;
            yaw_limit_reg  <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_KP_ROLL:    kp_roll_reg    <= cfg_data[GAIN_W-1:0];
                CFG_KP_PITCH:   kp_pitch_reg   <= cfg_data[GAIN_W-1:0];
                CFG_KP_YAW:     kp_yaw_reg     <= cfg_data[GAIN_W-1:0];
                CFG_KD_ROLL:    kd_roll_reg    <= cfg_data[GAIN_W-1:0];
                CFG_KD_PITCH:   kd_pitch_reg   <= cfg_data[GAIN_W-1:0];
                CFG_KD_YAW:     kd_yaw_reg     <= cfg_data[GAIN_W-1:0];
                CFG_TILT_LIMIT: tilt_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_YAW_LIMIT:  yaw_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the rates and form the six scaled gain terms.
    always_comb begin
        logic signed [DATA_W-1:0] gx;
        logic signed [DATA_W-1:0] gy;
        logic signed [DATA_W-1:0] gz;
        gx = clamp_sym(in_reg.gyro_x, tilt_limit_reg);
        gy = clamp_sym(in_reg.gyro_y, tilt_limit_reg);
        gz = clamp_sym(in_reg.gyro_z, yaw_limit_reg);
        terms.roll_p  = scale(kp_roll_reg, in_reg.roll_error);
        terms.roll_d  = scale(kd_roll_reg, gy);
        terms.pitch_p = scale(kp_pitch_reg, in_reg.pitch_error);
        terms.pitch_d = scale(kd_pitch_reg, gx);
        terms.yaw_p   = scale(kp_yaw_reg, in_reg.yaw_error);
        terms.yaw_d   = scale(kd_yaw_reg, gz);
        terms.thrust  = in_reg.thrust;
    end

    // Sum the corrections, mix into the four motors and saturate.
    always_comb begin
        logic signed [CORR_W-1:0] r;
        logic signed [CORR_W-1:0] p;
        logic signed [CORR_W-1:0] y;
        logic signed [MIX_W-1:0]  r_w;
        logic signed [MIX_W-1:0]  p_w;
        logic signed [MIX_W-1:0]  y_w;
        logic signed [MIX_W-1:0]  th;
        r = {terms.roll_p[SCALED_W-1], terms.roll_p}
          + {terms.roll_d[SCALED_W-1], terms.roll_d};
        p = {terms.pitch_p[SCALED_W-1], terms.pitch_p}
          + {terms.pitch_d[SCALED_W-1], terms.pitch_d};
        y = {terms.yaw_p[SCALED_W-1], terms.yaw_p}
          + {terms.yaw_d[SCALED_W-1], terms.yaw_d};
        r_w = {{(MIX_W - CORR_W){r[CORR_W-1]}}, r};
        p_w = {{(MIX_W - CORR_W){p[CORR_W-1]}}, p};
        y_w = {{(MIX_W - CORR_W){y[CORR_W-1]}}, y};
        th  = $signed({{(MIX_W - DATA_W){1'b0}}, terms.thrust});
        out_next.motor0 = sat_motor(th - p_w + y_w);
        out_next.motor1 = sat_motor(th - r_w - y_w);
        out_next.motor2 = sat_motor(th + p_w + y_w);
        out_next.motor3 = sat_motor(th + r_w - y_w);
    end

    // Valid flags of the two stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_reg <= in_item_t'(s_tdata);
        end
        if (out_ready && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    // Checks on the stall chain.
    `PDQMM_ASSERT_NEXT(a_accept_fills, aclk, aresetn,
        s_tvalid && s_tready, in_valid_reg,
        "accepted beat not held in the input register")
    `PDQMM_ASSERT_NEXT(a_in_to_out, aclk, aresetn,
        in_valid_reg && out_ready, m_tvalid,
        "beat lost between the input and the output register")
    `PDQMM_ASSERT_NOW(a_full_when_blocked, aclk, aresetn,
        !s_tready, in_valid_reg && out_valid_reg,
        "input stalled with a free stage")
    `PDQMM_ASSERT_NEXT(a_stall_keeps_result, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled result beat changed or dropped")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the quadcopter PD motor mixer top level.
// Depends on pdqmm_pkg and pd_quad_motor_mixer_top. It runs directed extremes and then
// randomized beats under several gain settings, checking every motor beat.

module tb_top;

    import pdqmm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_BEATS = 130;
    localparam longint MOTOR_HI = (longint'(1) <<< (MOTOR_W - 1)) - 1;
    localparam longint MOTOR_LO = -(longint'(1) <<< (MOTOR_W - 1));

    // One row of the directed stimulus: gain set, input beat, optional typed result.
    typedef struct {
        int        gain_set;
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the gain and limit registers, starting at their reset values.
    bit [GAIN_W-1:0]  roll_kp = 16'd256;
    bit [GAIN_W-1:0]  pitch_kp = 16'd256;
    bit [GAIN_W-1:0]  yaw_kp = 16'd256;
    bit [GAIN_W-1:0]  roll_kd = 16'd0;
    bit [GAIN_W-1:0]  pitch_kd = 16'd0;
    bit [GAIN_W-1:0]  yaw_kd = 16'd0;
    bit [LIMIT_W-1:0] tilt_lim = 15'h7FFF;
    bit [LIMIT_W-1:0] yaw_lim = 15'h7FFF;

    out_item_t motor_q[$];
    dir_row_t  dir_rows[$];
    int        mismatches = 0;
    int        stall_cycles = 0;
    bit        calm = 1'b0;

    // Gain sets used by the directed rows, in register index order.
    logic [15:0] gain_sets [5][8] = '{
        '{16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF},
        '{16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF},
        '{16'd300, 16'd0, 16'hFFFF, 16'hFFFF, 16'd128, 16'd1, 16'h8000, 16'h8000},
        '{16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100, 16'hC350}
    };

    pd_quad_motor_mixer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Gain times value, floor-shifted by the fractional bits of the gain.
    function automatic longint gain_term(bit [GAIN_W-1:0] gain, logic signed [DATA_W-1:0] x);
        longint prod;
        prod = longint'(gain) * longint'(x);
        return prod >>> GAIN_FRAC_BITS;
    endfunction

    // Symmetric rate clamp; a zero limit forces the rate to zero.
    function automatic longint clip_rate(logic signed [DATA_W-1:0] x, bit [LIMIT_W-1:0] lim);
        longint v;
        longint l;
        v = longint'(x);
        l = longint'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic logic signed [MOTOR_W-1:0] clip_motor(longint v);
        longint c;
        c = v;
        if (c > MOTOR_HI) c = MOTOR_HI;
        if (c < MOTOR_LO) c = MOTOR_LO;
        return c[MOTOR_W-1:0];
    endfunction

    // Expected motor commands for one input beat under the current gains.
    function automatic out_item_t mix_motors(in_item_t b);
        out_item_t o;
        longint roll_c;
        longint pitch_c;
        longint yaw_c;
        longint thr;
        roll_c  = gain_term(roll_kp, b.roll_error)
                + gain_term(roll_kd, DATA_W'(clip_rate(b.gyro_y, tilt_lim)));
        pitch_c = gain_term(pitch_kp, b.pitch_error)
                + gain_term(pitch_kd, DATA_W'(clip_rate(b.gyro_x, tilt_lim)));
        yaw_c   = gain_term(yaw_kp, b.yaw_error)
                + gain_term(yaw_kd, DATA_W'(clip_rate(b.gyro_z, yaw_lim)));
        thr = longint'(b.thrust);
        o.motor0 = clip_motor(thr - pitch_c + yaw_c);
        o.motor1 = clip_motor(thr - roll_c - yaw_c);
        o.motor2 = clip_motor(thr + pitch_c + yaw_c);
        o.motor3 = clip_motor(thr + roll_c - yaw_c);
        return o;
    endfunction

    function automatic in_item_t mk_in(int re, int pe, int ye, int gx, int gy, int gz, int th);
        in_item_t b;
        b.roll_error  = re[15:0];
        b.pitch_error = pe[15:0];
        b.yaw_error   = ye[15:0];
        b.gyro_x      = gx[15:0];
        b.gyro_y      = gy[15:0];
        b.gyro_z      = gz[15:0];
        b.thrust      = th[15:0];
        return b;
    endfunction

    function automatic out_item_t mk_out(int m0, int m1, int m2, int m3);
        out_item_t o;
        o.motor0 = m0[23:0];
        o.motor1 = m1[23:0];
        o.motor2 = m2[23:0];
        o.motor3 = m3[23:0];
        return o;
    endfunction

    function automatic void add_row(int gs, in_item_t b, bit typed, out_item_t want);
        dir_row_t r;
        r.gain_set = gs;
        r.beat     = b;
        r.typed    = typed;
        r.want     = want;
        dir_rows.push_back(r);
    endfunction

    // Random 16-bit field, weighted toward the extremes.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Random rate, often right at or just past the clamp limit.
    function automatic logic [15:0] pick_rate(bit [LIMIT_W-1:0] lim);
        logic [15:0] l;
        l = {1'b0, lim};
        case ($urandom_range(0, 7))
            0: return l;
            1: return -l;
            2: return l + 16'd1;
            3: return -l - 16'd1;
            default: return pick_word();
        endcase
    endfunction

    function automatic logic [15:0] pick_reg(cfg_reg_t r);
        if (r == CFG_TILT_LIMIT || r == CFG_YAW_LIMIT) begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                3: return 16'($urandom_range(0, 300));
                default: return 16'($urandom);
            endcase
        end
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0100;
            3: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    // One register write beat; the local copy keeps only the register's width.
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_KP_ROLL:    roll_kp = val;
            CFG_KP_PITCH:   pitch_kp = val;
            CFG_KP_YAW:     yaw_kp = val;
            CFG_KD_ROLL:    roll_kd = val;
            CFG_KD_PITCH:   pitch_kd = val;
            CFG_KD_YAW:     yaw_kd = val;
            CFG_TILT_LIMIT: tilt_lim = val[LIMIT_W-1:0];
            CFG_YAW_LIMIT:  yaw_lim = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every expected beat is back, then rewrites all registers.
    task automatic reload_gains(input logic [15:0] vals [8]);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (motor_q.size() != 0) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            write_reg(cfg_reg_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Sends one input beat, with an optional idle gap in front of it.
    task automatic push_beat(input in_item_t b, input bit typed, input out_item_t want);
        if (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        motor_q.push_back(typed ? want : mix_motors(b));
    endtask

    // Compares one motor beat with the oldest expectation.
    task automatic check_motors(input out_item_t got);
        out_item_t want;
        logic [MOTOR_W-1:0] g [4];
        logic [MOTOR_W-1:0] w [4];
        if (motor_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected motor beat %h", got);
            return;
        end
        want = motor_q.pop_front();
        g = '{got.motor0, got.motor1, got.motor2, got.motor3};
        w = '{want.motor0, want.motor1, want.motor2, want.motor3};
        for (int i = 0; i < 4; i++) begin
            if (g[i] !== w[i]) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("motor%0d mismatch: expected %0d got %0d",
                             i, $signed(w[i]), $signed(g[i]));
                end
            end
        end
    endtask

    // Result side: random back-pressure, checking and the stall watchdog.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_motors(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // Stimulus: directed table, then randomized phases under random gains.
    initial begin
        int          cur_set;
        logic [15:0] vals [8];
        in_item_t    b;

        // Reset gains: unity P terms, no D terms, so results read off directly.
        add_row(0, mk_in(0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0));
        add_row(0, mk_in(0, 0, 0, 0, 0, 0, 65535), 1, mk_out(65535, 65535, 65535, 65535));
        add_row(0, mk_in(32767, 0, 0, 0, 0, 0, 0), 1, mk_out(0, -32767, 0, 32767));
        add_row(0, mk_in(-32768, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 32768, 0, -32768));
        add_row(0, mk_in(0, 32767, 0, 0, 0, 0, 0), 1, mk_out(-32767, 0, 32767, 0));
        add_row(0, mk_in(0, -32768, 0, 0, 0, 0, 0), 1, mk_out(32768, 0, -32768, 0));
        add_row(0, mk_in(0, 0, 32767, 0, 0, 0, 0), 1, mk_out(32767, -32767, 32767, -32767));
        add_row(0, mk_in(0, 0, -32768, 0, 0, 0, 0), 1, mk_out(-32768, 32768, -32768, 32768));
        add_row(0, mk_in(0, 0, 0, -32768, 32767, -32768, 1234), 1,
                mk_out(1234, 1234, 1234, 1234));
        // Unity D gains, limits written with bit 15 set: the most negative rate clamps.
        add_row(1, mk_in(0, 0, 0, 0, -32768, 0, 0), 1, mk_out(0, 32767, 0, -32767));
        add_row(1, mk_in(0, 0, 0, 32767, 0, 0, 100), 1, mk_out(-32667, 100, 32867, 100));
        add_row(1, mk_in(0, 0, 0, 0, 0, -32768, 0), 1, mk_out(-32767, 32767, -32767, 32767));
        // Largest gains drive motors into saturation.
        add_row(2, mk_in(32767, 32767, 32767, 32767, 32767, 32767, 65535), 0, '0);
        add_row(2, mk_in(-32768, -32768, -32768, -32768, -32768, -32768, 0), 0, '0);
        add_row(2, mk_in(32767, -32768, 32767, -32768, 32767, -32768, 65535), 0, '0);
        add_row(2, mk_in(-32768, 32767, -32768, 32767, -32768, 32767, 0), 0, '0);
        // Zero limits force every rate to zero.
        add_row(3, mk_in(-1, 1, -32768, -32768, 32767, -32768, 40000), 0, '0);
        add_row(3, mk_in(12345, -23456, 32767, 32767, -32768, 32767, 7), 0, '0);
        // Only D terms, with small and odd limits.
        add_row(4, mk_in(32767, 32767, 32767, -32768, 32767, -32768, 32768), 0, '0);
        add_row(4, mk_in(-5, 5, -5, 99, -101, 17232, 65535), 0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reload registers whenever the row's gain set changes.
        cur_set = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].gain_set != cur_set) begin
                cur_set = dir_rows[i].gain_set;
                reload_gains(gain_sets[cur_set]);
            end
            push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part: each phase draws new registers; one phase runs without idling.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int i = 0; i < 8; i++) begin
                vals[i] = pick_reg(cfg_reg_t'(i));
            end
            reload_gains(vals);
            calm <= (ph == 2);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                b.roll_error  = pick_word();
                b.pitch_error = pick_word();
                b.yaw_error   = pick_word();
                b.gyro_x      = pick_rate(tilt_lim);
                b.gyro_y      = pick_rate(tilt_lim);
                b.gyro_z      = pick_rate(yaw_lim);
                b.thrust      = pick_word();
                push_beat(b, 1'b0, '0);
            end
        end

        // Drain, then allow for the pipeline depth before judging.
        s_tvalid <= 1'b0;
        calm <= 1'b0;
        @(posedge aclk);
        while (motor_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
